// ----- rtl/ssort_pkg.sv -----
// Shared types and constants for the selection sorter.
package ssort_pkg;

    localparam int C_DATA_W       = 32;
    localparam int C_MAX_ELEMENTS = 64;

    typedef logic signed [C_DATA_W-1:0] t_word;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SWAP1 = 5'b00100,
        S_SWAP2 = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

endpackage

// ----- rtl/ssort_store.sv -----
// Element store: single-port write, one registered read port.
module ssort_store #(
    parameter int DEPTH  = ssort_pkg::C_MAX_ELEMENTS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [ADDR_W-1:0]  i_wr_addr,
    input  ssort_pkg::t_word   i_wr_data,
    input  logic               i_rd_en,
    input  logic [ADDR_W-1:0]  i_rd_addr,
    output ssort_pkg::t_word   o_rd_data
);
    import ssort_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/selection_sorter_top.sv -----
// Top level of the selection sorter: loading, sort sequencer and output.
//
// Values are loaded one item per cycle while busy is low; an item with i_last set
// stores its value (if there is room) and starts the sort, and busy stays high until
// the final result has been shown. The sort and the output phase are both paced by the
// single read port of the element store, which is walked once per position to find
// the smallest remaining value, followed by a swap in the states S_SWAP1 and S_SWAP2.
// Results appear one per cycle, flagged by o_strobe, and cannot be held off by the
// receiver. Items beyond the store capacity are discarded and the final result then
// raises o_dropped.
module selection_sorter_top #(
    parameter int MAX_ELEMENTS = ssort_pkg::C_MAX_ELEMENTS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  ssort_pkg::t_word i_value,
    input  logic             i_last,
    output logic             o_strobe,
    output ssort_pkg::t_word o_sorted_value,
    output logic             o_final_res,
    output logic             o_dropped
);
    import ssort_pkg::*;

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CW-1:0] C_MAX = CW'(MAX_ELEMENTS);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_ovf, n_ovf;
    logic [CW-1:0]   r_pos, n_pos;
    logic [CW-1:0]   r_ra, n_ra;
    logic            r_dv;
    logic [AW-1:0]   r_di;
    t_word           r_best_val, n_best_val;
    logic [AW-1:0]   r_best_idx, n_best_idx;
    t_word           r_pos_val, n_pos_val;

    logic            w_accept;
    logic            w_issue;
    logic            w_wr_en;
    logic [AW-1:0]   w_wr_addr;
    t_word           w_wr_data;
    t_word           w_rd_data;
    logic [CW-1:0]   w_last_idx;
    logic            w_data_last;

    assign busy        = (r_state != S_IDLE);
    assign w_accept    = start && !busy;
    assign w_issue     = (r_state == S_SCAN || r_state == S_EMIT) && (r_ra < r_count);
    assign w_last_idx  = r_count - CW'(1);
    assign w_data_last = r_dv && (CW'(r_di) == w_last_idx);

    ssort_store #(
        .DEPTH  (MAX_ELEMENTS),
        .ADDR_W (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_ra[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_pos      = r_pos;
        n_ra       = r_ra;
        n_best_val = r_best_val;
        n_best_idx = r_best_idx;
        n_pos_val  = r_pos_val;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_count[AW-1:0];
        w_wr_data  = i_value;

        if (w_issue) begin
            n_ra = r_ra + CW'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (r_count < C_MAX) begin
                        w_wr_en = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last) begin
                        n_pos = '0;
                        n_ra  = '0;
                        if (n_count > CW'(1)) begin
                            n_state = S_SCAN;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (r_dv) begin
                    if (CW'(r_di) == r_pos) begin
                        n_best_val = w_rd_data;
                        n_best_idx = r_di;
                        n_pos_val  = w_rd_data;
                    end else if (w_rd_data < r_best_val) begin
                        n_best_val = w_rd_data;
                        n_best_idx = r_di;
                    end
                end
                if (w_data_last) begin
                    n_state = S_SWAP1;
                end
            end
            S_SWAP1: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_best_idx;
                w_wr_data = r_pos_val;
                n_state   = S_SWAP2;
            end
            S_SWAP2: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_pos[AW-1:0];
                w_wr_data = r_best_val;
                n_pos     = r_pos + CW'(1);
                if (r_pos + CW'(2) >= r_count) begin
                    n_ra    = '0;
                    n_state = S_EMIT;
                end else begin
                    n_ra    = r_pos + CW'(1);
                    n_state = S_SCAN;
                end
            end
            S_EMIT: begin
                if (w_data_last) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_dv    <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_ra       <= n_ra;
        r_di       <= r_ra[AW-1:0];
        r_best_val <= n_best_val;
        r_best_idx <= n_best_idx;
        r_pos_val  <= n_pos_val;
    end

    assign o_strobe       = (r_state == S_EMIT) && r_dv;
    assign o_sorted_value = w_rd_data;
    assign o_final_res    = o_strobe && w_data_last;
    assign o_dropped      = o_final_res && r_ovf;

    // The block only becomes ready again straight after the final item is shown.
    a_ready_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(o_final_res))
        else $error("busy fell without a final item");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("item shown while idle");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= C_MAX)
        else $error("element count beyond capacity");

    a_empty_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_final_res |=> (r_count == '0) && !r_ovf)
        else $error("store not emptied after final item");

endmodule
